[src/farthest_from_mean_color_finder_macros.svh]
// Assertion macros shared by the color finder RTL
`ifndef FARTHEST_FROM_MEAN_COLOR_FINDER_MACROS_SVH
`define FARTHEST_FROM_MEAN_COLOR_FINDER_MACROS_SVH

// Same-cycle implication, disabled in reset
`define FFM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset
`define FFM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/ffm_pkg.sv]
// Types and constants of the farthest-from-mean color finder
package ffm_pkg;

  localparam int CH_W       = 8;
  localparam int CFG_W      = 11;
  localparam int COL_OUT_W  = 10;
  localparam int ROW_OUT_W  = 9;
  localparam int SQ_W       = 2 * CH_W;
  localparam int DIST_W     = 18;
  localparam int DIV_STEPS  = CH_W;

  localparam logic [CFG_W-1:0] WIDTH_RESET = 11'd640;

  // channel select for the shared divider
  localparam logic [1:0] CH_R = 2'd0;
  localparam logic [1:0] CH_G = 2'd1;
  localparam logic [1:0] CH_B = 2'd2;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } px_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [CH_W-1:0] quot;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_LOAD  = 4'b0001,
    ST_DIV   = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_DRAIN = 4'b1000
  } state_t;

endpackage

[src/farthest_from_mean_color_finder.sv]
// Farthest-from-mean color finder: top level with sequencer and scan datapath
//
// Pixels of one frame arrive in raster order and are written one per cycle,
// whenever in_stall is low, into an on-chip frame store (MAX_WIDTH*MAX_HEIGHT
// entries of 24 bits) while the red, green and blue sums and the pixel count
// are kept. A request with last_pixel set closes the frame; in_stall then
// stays high until the result has been placed in the output register.
// Closing runs in three phases: (1) the mean color, each channel rounded to
// nearest with halves up, from a single shift-subtract divider shared by the
// three channels, one channel after another (start, eight quotient steps,
// hand-off); (2) a column-major scan of the stored frame, one store read per
// pixel and a column change between columns, feeding a squared-distance
// unit; (3) a drain of the scan pipeline. The pixel with the strictly largest
// squared distance wins, ties going to the lowest column, then the lowest
// row; if no pixel differs from the mean, the result is (0,0) with that
// pixel's color. A frame of N pixels has C scanned columns (the smaller of
// width and N), and its close is paced by the single read port of the frame
// store. The result waits in an output register, so loading of the next
// frame starts at once. frame_width (0 acts as 1, values above MAX_WIDTH as
// MAX_WIDTH) is written over the cfg_valid/cfg_ready port, which is always
// ready. Pixels beyond width*MAX_HEIGHT in one frame are dropped, but
// last_pixel on them still closes the frame. The frame store is not cleared;
// only entries of the current frame are read.
module farthest_from_mean_color_finder #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 512
) (
  input  logic                          clk,
  input  logic                          rst,
  // pixel requests
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ffm_pkg::CH_W-1:0]      red,
  input  logic [ffm_pkg::CH_W-1:0]      green,
  input  logic [ffm_pkg::CH_W-1:0]      blue,
  input  logic                          last_pixel,
  // width register
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ffm_pkg::CFG_W-1:0]     frame_width,
  // result requests
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ffm_pkg::COL_OUT_W-1:0] best_column,
  output logic [ffm_pkg::ROW_OUT_W-1:0] best_row,
  output logic [ffm_pkg::CH_W-1:0]      best_red,
  output logic [ffm_pkg::CH_W-1:0]      best_green,
  output logic [ffm_pkg::CH_W-1:0]      best_blue
);

`include "farthest_from_mean_color_finder_macros.svh"

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SUM_W  = ffm_pkg::CH_W + CNT_W;
  localparam int DVD_W  = SUM_W + 1;
  localparam int IDX_W  = CNT_W + 1;
  localparam int WW     = $clog2(MAX_WIDTH + 1);
  localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  // clamp the written width into 1..MAX_WIDTH
  function automatic logic [WW-1:0] clamp_width(input logic [ffm_pkg::CFG_W-1:0] d);
    logic [12:0] v;
    v = 13'(d);
    if (v == 13'd0) begin
      v = 13'd1;
    end else if (v > 13'(MAX_WIDTH)) begin
      v = 13'(MAX_WIDTH);
    end
    return WW'(v);
  endfunction

  function automatic logic [CNT_W-1:0] cap_of(input logic [WW-1:0] w);
    return CNT_W'(CNT_W'(w) * CNT_W'(MAX_HEIGHT));
  endfunction

  ffm_pkg::state_t state;

  // width in force and frame capacity, both updated on a write
  logic [WW-1:0]    w_eff;
  logic [CNT_W-1:0] cap;

  // load side
  logic             in_acc;
  logic             room;
  logic [CNT_W-1:0] pix_count;
  logic [SUM_W-1:0] sum_r, sum_g, sum_b;
  logic             wr_en;
  ffm_pkg::px_t     wr_data;

  // mean
  logic                  div_go;
  logic [1:0]            div_ch;
  logic [SUM_W-1:0]      div_sum;
  logic [DVD_W-1:0]      div_dividend;
  ffm_pkg::div_rsp_t     div_rsp;
  ffm_pkg::px_t          mean;

  // scan address generator
  logic [IDX_W-1:0] idx;
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic [WW-1:0]    col_next;
  logic             idx_in;
  logic             col_end;
  logic             rd_en;
  ffm_pkg::px_t     rd_data;

  // scan pipeline
  logic                       s1_valid;
  logic [COL_W-1:0]           s1_col, s2_col;
  logic [ROW_W-1:0]           s1_row, s2_row;
  ffm_pkg::px_t               s2_px;
  logic                       dist_valid;
  logic [ffm_pkg::DIST_W-1:0] distance;
  logic                       take;

  // running best
  logic [ffm_pkg::DIST_W-1:0] best_dist;
  logic [COL_W-1:0]           best_col;
  logic [ROW_W-1:0]           best_rw;
  ffm_pkg::px_t               best_px;

  logic drained;
  logic load_out;

  // ---------------- width register ----------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      w_eff <= clamp_width(ffm_pkg::WIDTH_RESET);
      cap   <= cap_of(clamp_width(ffm_pkg::WIDTH_RESET));
    end else if (cfg_valid && cfg_ready) begin
      w_eff <= clamp_width(frame_width);
      cap   <= cap_of(clamp_width(frame_width));
    end
  end

  // ---------------- load ----------------
  assign in_stall = state != ffm_pkg::ST_LOAD;
  assign in_acc   = in_valid && !in_stall;
  assign room     = pix_count < cap;
  assign wr_en    = in_acc && room;
  assign wr_data  = '{red: red, green: green, blue: blue};

  ffm_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (ADDR_W'(pix_count)),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (ADDR_W'(idx)),
    .rd_data (rd_data)
  );

  // ---------------- mean: (sum + count/2) / count ----------------
  always_comb begin
    unique case (div_ch)
      ffm_pkg::CH_R: div_sum = sum_r;
      ffm_pkg::CH_G: div_sum = sum_g;
      ffm_pkg::CH_B: div_sum = sum_b;
      default:       div_sum = '0;
    endcase
  end

  assign div_dividend = DVD_W'(div_sum) + DVD_W'(pix_count >> 1);

  ffm_div #(
    .DVD_W (DVD_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_go),
    .dividend (div_dividend),
    .divisor  (DVD_W'(pix_count)),
    .rsp      (div_rsp)
  );

  // ---------------- scan: column by column, top to bottom ----------------
  assign idx_in   = idx < IDX_W'(pix_count);
  assign col_next = WW'(col) + WW'(1);
  assign col_end  = (col_next == w_eff) || (IDX_W'(col_next) >= IDX_W'(pix_count));
  assign rd_en    = (state == ffm_pkg::ST_SCAN) && idx_in;

  ffm_dist u_dist (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .px        (rd_data),
    .mean      (mean),
    .out_valid (dist_valid),
    .distance  (distance)
  );

  // first scanned pixel seeds the best, so an all-equal frame reports (0,0)
  assign take = dist_valid &&
                (((s2_col == '0) && (s2_row == '0)) || (distance > best_dist));

  assign drained  = !s1_valid && !dist_valid;
  assign load_out = (state == ffm_pkg::ST_DRAIN) && drained &&
                    (!out_valid || !out_stall);

  // ---------------- sequencer and control state ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ffm_pkg::ST_LOAD;
      pix_count <= '0;
      sum_r     <= '0;
      sum_g     <= '0;
      sum_b     <= '0;
      div_go    <= 1'b0;
      div_ch    <= ffm_pkg::CH_R;
      idx       <= '0;
      col       <= '0;
      row       <= '0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // start pulse: frame closed, or next channel after a finished one
      div_go    <= ((state == ffm_pkg::ST_LOAD) && in_acc && last_pixel) ||
                   ((state == ffm_pkg::ST_DIV) && div_rsp.done &&
                    (div_ch != ffm_pkg::CH_B));
      s1_valid  <= rd_en;
      out_valid <= load_out || (out_valid && out_stall);
      unique case (state)
        ffm_pkg::ST_LOAD: begin
          if (wr_en) begin
            pix_count <= pix_count + CNT_W'(1);
            sum_r     <= sum_r + SUM_W'(red);
            sum_g     <= sum_g + SUM_W'(green);
            sum_b     <= sum_b + SUM_W'(blue);
          end
          if (in_acc && last_pixel) begin
            state  <= ffm_pkg::ST_DIV;
            div_ch <= ffm_pkg::CH_R;
          end
        end
        ffm_pkg::ST_DIV: begin
          if (div_rsp.done) begin
            if (div_ch == ffm_pkg::CH_B) begin
              state <= ffm_pkg::ST_SCAN;
              idx   <= '0;
              col   <= '0;
              row   <= '0;
            end else begin
              div_ch <= div_ch + 2'd1;
            end
          end
        end
        ffm_pkg::ST_SCAN: begin
          if (idx_in) begin
            idx <= idx + IDX_W'(w_eff);
            row <= row + ROW_W'(1);
          end else if (col_end) begin
            state <= ffm_pkg::ST_DRAIN;
          end else begin
            col <= COL_W'(col_next);
            row <= '0;
            idx <= IDX_W'(col_next);
          end
        end
        ffm_pkg::ST_DRAIN: begin
          if (load_out) begin
            state     <= ffm_pkg::ST_LOAD;
            pix_count <= '0;
            sum_r     <= '0;
            sum_g     <= '0;
            sum_b     <= '0;
          end
        end
        default: begin
          state <= ffm_pkg::ST_LOAD;
        end
      endcase
    end
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk) begin
    if (div_rsp.done) begin
      unique case (div_ch)
        ffm_pkg::CH_R: mean.red   <= div_rsp.quot;
        ffm_pkg::CH_G: mean.green <= div_rsp.quot;
        ffm_pkg::CH_B: mean.blue  <= div_rsp.quot;
        default:       mean       <= mean;
      endcase
    end
    if (rd_en) begin
      s1_col <= col;
      s1_row <= row;
    end
    if (s1_valid) begin
      s2_col <= s1_col;
      s2_row <= s1_row;
      s2_px  <= rd_data;
    end
    if (take) begin
      best_dist <= distance;
      best_col  <= s2_col;
      best_rw   <= s2_row;
      best_px   <= s2_px;
    end
    if (load_out) begin
      best_column <= ffm_pkg::COL_OUT_W'(best_col);
      best_row    <= ffm_pkg::ROW_OUT_W'(best_rw);
      best_red    <= best_px.red;
      best_green  <= best_px.green;
      best_blue   <= best_px.blue;
    end
  end

  // ---------------- assertions ----------------
  `FFM_ASSERT_IMP(a_div_start_idle, div_go, !div_rsp.busy, "divider restarted while busy")
  `FFM_ASSERT_IMP(a_dist_in_scan, dist_valid,
    (state == ffm_pkg::ST_SCAN) || (state == ffm_pkg::ST_DRAIN), "distance outside scan")
  `FFM_ASSERT_IMP(a_out_after_drain, $rose(out_valid),
    $past(state == ffm_pkg::ST_DRAIN), "result loaded before scan drained")
  `FFM_ASSERT_IMP(a_scan_nonempty, state == ffm_pkg::ST_SCAN,
    pix_count != '0, "scan of an empty frame")
  `FFM_ASSERT_NXT(a_last_closes, in_acc && last_pixel,
    state == ffm_pkg::ST_DIV, "last pixel did not close the frame")

endmodule

[src/ffm_store.sv]
// Frame store: one write port, one registered read port
module ffm_store #(
  parameter int DEPTH = 524288,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  ffm_pkg::px_t      wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output ffm_pkg::px_t      rd_data
);

  ffm_pkg::px_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[src/ffm_div.sv]
// Shift-subtract divider, one quotient bit per cycle, quotient known < 2^CH_W
module ffm_div #(
  parameter int DVD_W = 30
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [DVD_W-1:0]    dividend,
  input  logic [DVD_W-1:0]    divisor,
  output ffm_pkg::div_rsp_t   rsp
);

  localparam int STEP_W = (ffm_pkg::DIV_STEPS > 1) ? $clog2(ffm_pkg::DIV_STEPS) : 1;

  logic [DVD_W-1:0]         rem;
  logic [DVD_W-1:0]         den;
  logic [ffm_pkg::CH_W-1:0] quot;
  logic [STEP_W-1:0]        step;
  logic                     busy;
  logic                     done;
  logic                     ge;
  logic                     last_step;

  assign ge        = rem >= den;
  assign last_step = step == STEP_W'(ffm_pkg::DIV_STEPS - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && last_step;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && last_step) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= dividend;
      den  <= divisor << (ffm_pkg::DIV_STEPS - 1);
      quot <= '0;
      step <= '0;
    end else if (busy) begin
      rem  <= ge ? rem - den : rem;
      den  <= den >> 1;
      quot <= {quot[ffm_pkg::CH_W-2:0], ge};
      step <= step + STEP_W'(1);
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quot = quot;

endmodule

[src/ffm_dist.sv]
// Squared color distance to the mean: registered squares, summed on the way out
module ffm_dist (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  ffm_pkg::px_t               px,
  input  ffm_pkg::px_t               mean,
  output logic                       out_valid,
  output logic [ffm_pkg::DIST_W-1:0] distance
);

  logic [ffm_pkg::CH_W-1:0] ad_r, ad_g, ad_b;
  logic [ffm_pkg::SQ_W-1:0] sq_r, sq_g, sq_b;

  function automatic logic [ffm_pkg::CH_W-1:0] abs_diff(
    input logic [ffm_pkg::CH_W-1:0] a,
    input logic [ffm_pkg::CH_W-1:0] b
  );
    return (a > b) ? a - b : b - a;
  endfunction

  always_comb begin
    ad_r = abs_diff(mean.red,   px.red);
    ad_g = abs_diff(mean.green, px.green);
    ad_b = abs_diff(mean.blue,  px.blue);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      sq_r <= ffm_pkg::SQ_W'(ad_r) * ffm_pkg::SQ_W'(ad_r);
      sq_g <= ffm_pkg::SQ_W'(ad_g) * ffm_pkg::SQ_W'(ad_g);
      sq_b <= ffm_pkg::SQ_W'(ad_b) * ffm_pkg::SQ_W'(ad_b);
    end
  end

  // max 3*255^2 fits the 18-bit distance
  assign distance = ffm_pkg::DIST_W'(sq_r) + ffm_pkg::DIST_W'(sq_g) + ffm_pkg::DIST_W'(sq_b);

endmodule

[tb/farthest_from_mean_color_finder_tb.sv]
// Testbench: farthest-from-mean color finder, directed rows then random frames
module farthest_from_mean_color_finder_tb;

  localparam int MAX_W = 1024;
  localparam int MAX_H = 512;
  localparam int PIXEL_TARGET = 1050;
  localparam int DRAIN_CYCLES = 50;

  // one expected result: where the farthest pixel sits and its color
  typedef struct packed {
    logic [ffm_pkg::COL_OUT_W-1:0] column;
    logic [ffm_pkg::ROW_OUT_W-1:0] row;
    ffm_pkg::px_t                  color;
  } spot_t;

  // directed stimulus row; the want_* fields count only when typed is set
  typedef struct packed {
    logic                          set_width;
    logic [ffm_pkg::CFG_W-1:0]     width;
    logic [ffm_pkg::CH_W-1:0]      red, green, blue;
    logic                          last;
    logic                          typed;
    logic [ffm_pkg::COL_OUT_W-1:0] want_column;
    logic [ffm_pkg::ROW_OUT_W-1:0] want_row;
    logic [ffm_pkg::CH_W-1:0]      want_red, want_green, want_blue;
  } directed_row_t;

  // pixel color generators for random frames
  typedef enum int {
    PAT_UNIFORM,
    PAT_JITTER,
    PAT_EXTREME,
    PAT_FLAT
  } pattern_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [ffm_pkg::CH_W-1:0]      red = '0;
  logic [ffm_pkg::CH_W-1:0]      green = '0;
  logic [ffm_pkg::CH_W-1:0]      blue = '0;
  logic                          last_pixel = 1'b0;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [ffm_pkg::CFG_W-1:0]     frame_width = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [ffm_pkg::COL_OUT_W-1:0] best_column;
  logic [ffm_pkg::ROW_OUT_W-1:0] best_row;
  logic [ffm_pkg::CH_W-1:0]      best_red;
  logic [ffm_pkg::CH_W-1:0]      best_green;
  logic [ffm_pkg::CH_W-1:0]      best_blue;

  // predictor state: width in force and the pixels stored in the open frame
  logic [ffm_pkg::CFG_W-1:0] width_setting = ffm_pkg::WIDTH_RESET;
  ffm_pkg::px_t              frame_px[$];
  spot_t                     spot_queue[$];

  int  mismatches = 0;
  int  pixels_sent = 0;
  bit  quiet_phase = 1'b0;
  int  stall_run = 0;

  always #2 clk = ~clk;

  farthest_from_mean_color_finder u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .last_pixel  (last_pixel),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .frame_width (frame_width),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .best_column (best_column),
    .best_row    (best_row),
    .best_red    (best_red),
    .best_green  (best_green),
    .best_blue   (best_blue)
  );

  // Directed rows. Typed expectations only for frames whose answer is obvious:
  // a lone pixel or a flat frame lands on (0,0) with the first pixel's color.
  directed_row_t directed_rows [0:19] = '{
    // single pixel right after reset, width 640
    '{0, 0, 255, 0, 128, 1, 1, 0, 0, 255, 0, 128},
    // flat frame: no pixel above distance zero
    '{0, 0, 7, 7, 7, 0, 0, 0, 0, 0, 0, 0},
    '{0, 0, 7, 7, 7, 0, 0, 0, 0, 0, 0, 0},
    '{0, 0, 7, 7, 7, 1, 1, 0, 0, 7, 7, 7},
    // black and white extremes
    '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 0, 255, 255, 255, 1, 0, 0, 0, 0, 0, 0},
    // width 2, tie between (col 1,row 0) and (col 0,row 1): lower column wins
    '{1, 2, 20, 20, 20, 0, 0, 0, 0, 0, 0, 0},
    '{0, 0, 40, 40, 40, 0, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 0, 20, 20, 20, 1, 0, 0, 0, 0, 0, 0},
    // width 2, partial last row
    '{0, 0, 0, 255, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 0, 255, 0, 255, 0, 0, 0, 0, 0, 0, 0},
    '{0, 0, 255, 0, 255, 1, 0, 0, 0, 0, 0, 0},
    // width 0 behaves as a single column
    '{1, 0, 1, 2, 3, 0, 0, 0, 0, 0, 0, 0},
    '{0, 0, 200, 100, 50, 0, 0, 0, 0, 0, 0, 0},
    '{0, 0, 3, 2, 1, 1, 0, 0, 0, 0, 0, 0},
    // all-ones width clamps to the max; mean rounds halves up
    '{1, 2047, 128, 128, 128, 0, 0, 0, 0, 0, 0, 0},
    '{0, 0, 129, 127, 128, 1, 0, 0, 0, 0, 0, 0},
    // exactly the max width
    '{1, 1024, 170, 85, 255, 0, 0, 0, 0, 0, 0, 0},
    '{0, 0, 85, 170, 0, 1, 0, 0, 0, 0, 0, 0}
  };

  function automatic int clamp_width(input logic [ffm_pkg::CFG_W-1:0] w);
    if (w == 0) return 1;
    if (w > MAX_W) return MAX_W;
    return int'(w);
  endfunction

  // Store one accepted pixel into the predicted frame; on the frame's last
  // pixel, search column-major for the strictly farthest color from the mean.
  function automatic bit farthest_pixel(input ffm_pkg::px_t px, input bit last,
                                        output spot_t spot);
    int w, count, best_idx, best_dist, sq_sum, d;
    int sums[3];
    int mean[3];
    int ch[3];
    ffm_pkg::px_t p;
    w = clamp_width(width_setting);
    spot = '0;
    // pixels past the frame capacity are dropped, but last still closes
    if (frame_px.size() < w * MAX_H) frame_px.insert(frame_px.size(), px);
    if (!last) return 1'b0;
    count = frame_px.size();
    sums = '{0, 0, 0};
    foreach (frame_px[i]) begin
      sums[0] += frame_px[i].red;
      sums[1] += frame_px[i].green;
      sums[2] += frame_px[i].blue;
    end
    for (int k = 0; k < 3; k++) mean[k] = (sums[k] + count / 2) / count;
    best_idx = 0;
    best_dist = 0;
    for (int x = 0; x < w; x++) begin
      for (int idx = x; idx < count; idx += w) begin
        p = frame_px[idx];
        ch = '{int'(p.red), int'(p.green), int'(p.blue)};
        sq_sum = 0;
        for (int k = 0; k < 3; k++) begin
          d = mean[k] - ch[k];
          sq_sum += d * d;
        end
        if (sq_sum > best_dist) begin
          best_dist = sq_sum;
          best_idx = idx;
        end
      end
    end
    spot.column = ffm_pkg::COL_OUT_W'(best_idx % w);
    spot.row = ffm_pkg::ROW_OUT_W'(best_idx / w);
    spot.color = frame_px[best_idx];
    frame_px.delete();
    return 1'b1;
  endfunction

  // mostly back-to-back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (quiet_phase) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic ffm_pkg::px_t make_pixel(input pattern_t pat, input ffm_pkg::px_t base);
    ffm_pkg::px_t px;
    case (pat)
      PAT_UNIFORM: begin
        px.red = 8'($urandom_range(0, 255));
        px.green = 8'($urandom_range(0, 255));
        px.blue = 8'($urandom_range(0, 255));
      end
      PAT_JITTER: begin
        // near-constant colors: lots of ties and tiny distances
        px.red = base.red ^ 8'($urandom_range(0, 1));
        px.green = base.green ^ 8'($urandom_range(0, 1));
        px.blue = base.blue ^ 8'($urandom_range(0, 1));
      end
      PAT_EXTREME: begin
        px.red = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        px.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        px.blue = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
      default: px = base;
    endcase
    return px;
  endfunction

  // Present one pixel request, hold it through stalls, then update the
  // predictor at the accepting edge. A typed row overrides the prediction.
  task automatic drive_pixel(input ffm_pkg::px_t px, input bit last, input bit typed,
                             input spot_t want);
    spot_t predicted;
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    red <= px.red;
    green <= px.green;
    blue <= px.blue;
    last_pixel <= last;
    do @(posedge clk); while (in_stall);
    if (farthest_pixel(px, last, predicted)) begin
      spot_queue.insert(spot_queue.size(), typed ? want : predicted);
    end
    pixels_sent++;
  endtask

  // Width writes happen only with the block idle: all results back, plus a
  // margin of idle clocks.
  task automatic write_width(input logic [ffm_pkg::CFG_W-1:0] w);
    @(negedge clk);
    in_valid <= 1'b0;
    while (spot_queue.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    frame_width <= w;
    do @(posedge clk); while (!cfg_ready);
    width_setting = w;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Result side stall: alternating runs, mostly short stalls, a few long.
  always @(negedge clk) begin
    if (quiet_phase) begin
      out_stall <= 1'b0;
    end else if (stall_run > 0) begin
      stall_run <= stall_run - 1;
    end else if (out_stall) begin
      out_stall <= 1'b0;
      stall_run <= $urandom_range(0, 12);
    end else begin
      out_stall <= 1'b1;
      stall_run <= ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50) : $urandom_range(0, 2);
    end
  end

  // Every accepted result is matched against the oldest expectation.
  always @(posedge clk) begin : result_check
    spot_t want;
    if (!rst && out_valid && !out_stall) begin
      if (spot_queue.size() == 0) begin
        $error("unexpected result: column %0d row %0d", best_column, best_row);
        mismatches++;
      end else begin
        want = spot_queue.pop_front();
        compare_field("best_column", want.column, best_column);
        compare_field("best_row", want.row, best_row);
        compare_field("best_red", want.color.red, best_red);
        compare_field("best_green", want.color.green, best_green);
        compare_field("best_blue", want.color.blue, best_blue);
      end
    end
  end

  initial begin : stimulus
    directed_row_t row_entry;
    spot_t want;
    ffm_pkg::px_t base, px;
    pattern_t pat;
    int phase, frames, len, r;
    logic [ffm_pkg::CFG_W-1:0] w;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part
    foreach (directed_rows[i]) begin
      row_entry = directed_rows[i];
      if (row_entry.set_width) write_width(row_entry.width);
      px = '{row_entry.red, row_entry.green, row_entry.blue};
      want.column = row_entry.want_column;
      want.row = row_entry.want_row;
      want.color = '{row_entry.want_red, row_entry.want_green, row_entry.want_blue};
      drive_pixel(px, row_entry.last, row_entry.typed, want);
    end

    // random part: phases of frames, each phase under one width setting
    phase = 0;
    while (pixels_sent < PIXEL_TARGET) begin
      r = $urandom_range(0, 99);
      if (phase == 2) w = '0;  // single column, used for the overflow frame
      else if (r < 70) w = ffm_pkg::CFG_W'($urandom_range(1, 8));
      else if (r < 78) w = '0;
      else if (r < 86) w = ffm_pkg::CFG_W'($urandom_range(9, 64));
      else if (r < 92) w = ($urandom_range(0, 1) != 0) ? 11'd1024 : 11'd640;
      else w = ($urandom_range(0, 1) != 0) ? 11'd2047 : ffm_pkg::CFG_W'($urandom_range(1025, 2046));
      quiet_phase = ($urandom_range(0, 4) == 0);
      write_width(w);
      frames = $urandom_range(2, 8);
      for (int f = 0; f < frames; f++) begin
        if (pixels_sent >= PIXEL_TARGET) break;
        r = $urandom_range(0, 99);
        // overflow: more than width*MAX_H pixels, last mark on a dropped one
        if (phase == 2 && f == 0) len = MAX_H + $urandom_range(1, 6);
        else if (r < 80) len = $urandom_range(1, 8);
        else if (r < 95) len = $urandom_range(9, 24);
        else len = $urandom_range(25, 70);
        pat = pattern_t'($urandom_range(0, 3));
        base = make_pixel(PAT_UNIFORM, '0);
        for (int i = 0; i < len; i++) begin
          px = make_pixel(pat, base);
          drive_pixel(px, i == len - 1, 1'b0, '0);
        end
      end
      phase++;
    end

    // drain: all results back, then a margin for anything stray
    @(negedge clk);
    in_valid <= 1'b0;
    quiet_phase = 1'b0;
    while (spot_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin : watchdog
    #20000000;
    $display("Verification failed");
    $finish;
  end

endmodule
